@@ hdl/sef_pkg.sv @@
package sef_pkg;

  localparam int SW_MAX       = 3;
  localparam int NUM_SWITCHES = 3;
  localparam int SW_USED      = (NUM_SWITCHES > SW_MAX) ? SW_MAX : NUM_SWITCHES;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_TOP  = 8'h80;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // position of a byte inside one packet
  localparam logic [2:0] BYTE_HDR  = 3'd0;
  localparam logic [2:0] BYTE_CMD  = 3'd1;
  localparam logic [2:0] BYTE_ARG  = 3'd2;
  localparam logic [2:0] BYTE_CRC  = 3'd3;
  localparam logic [2:0] BYTE_TAIL = 3'd4;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_LINK_READY = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEADER     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COMMAND    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TAIL       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ARG_WIFI   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ARG_POWER  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ARG_MODE   = 3'd6;

  typedef logic [SW_MAX-1:0] sw_mask_t;

  typedef struct packed {
    logic wifi_on;
    logic power_on;
    logic mode_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       packet_end;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic       link_ready;
    logic [7:0] header_byte;
    logic [7:0] command_byte;
    logic [7:0] tail_byte;
    logic [7:0] arg_wifi;
    logic [7:0] arg_power;
    logic [7:0] arg_mode;
  } cfg_t;

  // edge queue handshake between the front and the back
  typedef struct packed {
    logic     pop;
  } q_req_t;

  typedef struct packed {
    logic     empty;
    sw_mask_t mask;
  } q_rsp_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/sef_front.sv @@
module sef_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              link_ready,
  input  logic              push,
  input  sef_pkg::in_item_t item,
  input  logic              q_full,
  output logic              q_push,
  output sef_pkg::sw_mask_t q_mask
);

  sef_pkg::sw_mask_t prev_r, prev_nxt;
  sef_pkg::sw_mask_t level;
  sef_pkg::sw_mask_t rise;
  logic              take;

  assign level = {item.mode_on, item.power_on, item.wifi_on};
  assign take  = push && !q_full && link_ready;

  always_comb begin
    prev_nxt = prev_r;
    rise     = '0;
    for (int i = 0; i < sef_pkg::SW_MAX; i++) begin
      if (i < sef_pkg::SW_USED) begin
        rise[i] = level[i] && !prev_r[i];
        if (take) begin
          prev_nxt[i] = level[i];
        end
      end
    end
  end

  // ticks with no rising switch leave nothing for the back end
  assign q_push = take && (rise != '0);
  assign q_mask = rise;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '1;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

@@ hdl/sef_queue.sv @@
module sef_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sef_pkg::sw_mask_t push_mask,
  output logic              full,
  input  sef_pkg::q_req_t   req,
  output sef_pkg::q_rsp_t   rsp
);

  sef_pkg::sw_mask_t             mem_r [sef_pkg::Q_DEPTH];
  logic [sef_pkg::Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [sef_pkg::Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [sef_pkg::Q_CW-1:0]      count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full      = (count_r == sef_pkg::Q_CW'(sef_pkg::Q_DEPTH));
  assign rsp.empty = (count_r == '0);
  assign rsp.mask  = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = req.pop && !rsp.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_mask;
    end
  end

endmodule

@@ hdl/sef_back.sv @@
module sef_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sef_pkg::cfg_t      cfg,
  input  sef_pkg::q_rsp_t    q_rsp,
  output sef_pkg::q_req_t    q_req,
  input  logic               out_pop,
  output logic               out_empty,
  output sef_pkg::out_item_t out_item
);

  sef_pkg::sw_mask_t  mask_r, mask_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic               out_valid_r, out_valid_nxt;
  sef_pkg::out_item_t out_r, out_nxt;
  sef_pkg::sw_mask_t  sel;
  sef_pkg::sw_mask_t  rest;
  logic [7:0]         arg;
  logic               busy, emit;
  sef_pkg::out_item_t beat;

  assign busy = (mask_r != '0);
  assign emit = busy && (!out_valid_r || out_pop);
  assign sel  = mask_r & (~mask_r + 1'b1);
  assign rest = mask_r & ~sel;

  always_comb begin
    case (sel)
      3'b001:  arg = cfg.arg_wifi;
      3'b010:  arg = cfg.arg_power;
      default: arg = cfg.arg_mode;
    endcase
  end

  always_comb begin
    beat     = '0;
    crc_nxt  = crc_r;
    idx_nxt  = idx_r;
    mask_nxt = mask_r;
    case (idx_r)
      sef_pkg::BYTE_HDR: begin
        beat.tx_byte = cfg.header_byte;
        crc_nxt      = sef_pkg::crc_feed(sef_pkg::CRC_INIT, cfg.header_byte);
        idx_nxt      = sef_pkg::BYTE_CMD;
      end
      sef_pkg::BYTE_CMD: begin
        beat.tx_byte = cfg.command_byte;
        crc_nxt      = sef_pkg::crc_feed(crc_r, cfg.command_byte);
        idx_nxt      = sef_pkg::BYTE_ARG;
      end
      sef_pkg::BYTE_ARG: begin
        beat.tx_byte = arg;
        crc_nxt      = sef_pkg::crc_feed(crc_r, arg);
        idx_nxt      = sef_pkg::BYTE_CRC;
      end
      sef_pkg::BYTE_CRC: begin
        // tail byte closes the checksum before it is sent
        beat.tx_byte = sef_pkg::crc_feed(crc_r, cfg.tail_byte);
        idx_nxt      = sef_pkg::BYTE_TAIL;
      end
      default: begin
        beat.tx_byte    = cfg.tail_byte;
        beat.packet_end = 1'b1;
        beat.run_last   = (rest == '0);
        idx_nxt         = sef_pkg::BYTE_HDR;
        mask_nxt        = rest;
      end
    endcase
    if (!emit) begin
      crc_nxt  = crc_r;
      idx_nxt  = idx_r;
      mask_nxt = mask_r;
    end
    q_req.pop = !busy && !q_rsp.empty;
    if (q_req.pop) begin
      mask_nxt = q_rsp.mask;
      idx_nxt  = sef_pkg::BYTE_HDR;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = beat;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      idx_r       <= sef_pkg::BYTE_HDR;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    out_r <= out_nxt;
  end

endmodule

@@ hdl/switch_edge_command_framer.sv @@
// Turns switch level ticks into five-byte command packets (header, command, argument,
// CRC-8 with polynomial 0x31 over header, command, argument and tail, then tail), one
// packet per switch that rises from inactive to active, scanned wifi, power, mode.
// A tick is taken every cycle while the four-entry edge queue between the front end
// and the packet sequencer has room; ticks are ignored while link_ready is zero.
// The sequencer sends one byte per cycle while the output is empty or being popped,
// so a tick with k rising switches yields 5*k beats. Switches that are already active
// after reset send nothing until they have been seen inactive.
module switch_edge_command_framer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  sef_pkg::in_item_t                in_item,
  output logic                             out_empty,
  input  logic                             out_pop,
  output sef_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  logic [sef_pkg::REG_IDX_W-1:0]    cfg_idx,
  input  logic [7:0]                       cfg_data
);

  sef_pkg::cfg_t     cfg_r, cfg_nxt;
  logic              q_push, q_full;
  sef_pkg::sw_mask_t q_mask;
  sef_pkg::q_req_t   q_req;
  sef_pkg::q_rsp_t   q_rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        sef_pkg::REG_LINK_READY: cfg_nxt.link_ready   = cfg_data[0];
        sef_pkg::REG_HEADER:     cfg_nxt.header_byte  = cfg_data;
        sef_pkg::REG_COMMAND:    cfg_nxt.command_byte = cfg_data;
        sef_pkg::REG_TAIL:       cfg_nxt.tail_byte    = cfg_data;
        sef_pkg::REG_ARG_WIFI:   cfg_nxt.arg_wifi     = cfg_data;
        sef_pkg::REG_ARG_POWER:  cfg_nxt.arg_power    = cfg_data;
        sef_pkg::REG_ARG_MODE:   cfg_nxt.arg_mode     = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_full;

  sef_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .link_ready (cfg_r.link_ready),
    .push       (in_push),
    .item       (in_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_mask     (q_mask)
  );

  sef_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_mask (q_mask),
    .full      (q_full),
    .req       (q_req),
    .rsp       (q_rsp)
  );

  sef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rsp     (q_rsp),
    .q_req     (q_req),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
